// ===== rtl/core/sdeq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sdeq_pkg;

  localparam int CAPACITY = 16;
  localparam int VALUE_W  = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int COUNT_W  = 5;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_INSERT     = 2'd0;
  localparam logic [OP_W-1:0] OP_REM_LARGE  = 2'd1;
  localparam logic [OP_W-1:0] OP_REM_SMALL  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                       ins;
    logic                       rem_head;
    logic signed [VALUE_W-1:0]  value;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/sorted_double_ended_queue_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// the result of an accepted input transaction is registered and shows on the master side in the next cycle
// throughput: one transaction per cycle while the master side takes results, as the whole cell chain updates at once
// a result waiting in the output register does not block input while it is being taken
// reset (rst_ni low, asynchronous) empties the queue and drops any pending result
// cell contents are not reset; only positions below the count are ever read
module sorted_double_ended_queue_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [31:0] s_axis_tdata_i,   // [31:0] value
  input  wire  [1:0]  s_axis_tuser_i,   // [1:0] op
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [31:0] largest, [63:32] smallest, [68:64] count, pad
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);
  import sdeq_pkg::*;

  logic                      accept;
  logic [CNT_W-1:0]          count_q;
  logic [CNT_W-1:0]          count_d;
  logic [STATUS_W-1:0]       status_d;
  logic                      do_ins;
  logic                      do_rem_head;
  logic                      do_rem_tail;
  cmd_t                      cmd;

  logic                      occ   [CAPACITY];
  logic                      keep  [CAPACITY];
  logic signed [VALUE_W-1:0] cur   [CAPACITY];
  logic signed [VALUE_W-1:0] nxt   [CAPACITY];

  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] largest_q;
  logic signed [VALUE_W-1:0] smallest_q;
  logic [CNT_W-1:0]          count_out_q;
  logic [STATUS_W-1:0]       status_q;
  logic [IDX_W-1:0]          tail_idx;

  // output register frees up as soon as its result is taken
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // decode the operation and its rejection cases
  always_comb begin
    do_ins      = 1'b0;
    do_rem_head = 1'b0;
    do_rem_tail = 1'b0;
    status_d    = ST_DONE;
    case (s_axis_tuser_i)
      OP_INSERT: begin
        if (count_q >= CNT_W'(CAPACITY)) begin
          status_d = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_REM_LARGE: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          do_rem_head = 1'b1;
        end
      end
      OP_REM_SMALL: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          do_rem_tail = 1'b1;
        end
      end
      default: begin
        status_d = ST_DONE;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + 1'b1;
    end else if (do_rem_head || do_rem_tail) begin
      count_d = count_q - 1'b1;
    end
  end

  assign cmd.ins      = do_ins;
  assign cmd.rem_head = do_rem_head;
  assign cmd.value    = $signed(s_axis_tdata_i[VALUE_W-1:0]);

  // chain of cells, head at index 0; inner cells see both neighbors, the end cells only one
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_head
      sdeq_cell u_cell (
        .clk_i         (clk_i),
        .en_i          (accept),
        .cmd_i         (cmd),
        .occ_i         (occ[i]),
        .left_keep_i   (1'b1),
        .left_value_i  (cur[i]),
        .right_value_i (cur[i+1]),
        .keep_o        (keep[i]),
        .value_o       (cur[i]),
        .next_o        (nxt[i])
      );
    end else if (i == CAPACITY - 1) begin : g_tail
      sdeq_cell u_cell (
        .clk_i         (clk_i),
        .en_i          (accept),
        .cmd_i         (cmd),
        .occ_i         (occ[i]),
        .left_keep_i   (keep[i-1]),
        .left_value_i  (cur[i-1]),
        .right_value_i (cur[i]),
        .keep_o        (keep[i]),
        .value_o       (cur[i]),
        .next_o        (nxt[i])
      );
    end else begin : g_mid
      sdeq_cell u_cell (
        .clk_i         (clk_i),
        .en_i          (accept),
        .cmd_i         (cmd),
        .occ_i         (occ[i]),
        .left_keep_i   (keep[i-1]),
        .left_value_i  (cur[i-1]),
        .right_value_i (cur[i+1]),
        .keep_o        (keep[i]),
        .value_o       (cur[i]),
        .next_o        (nxt[i])
      );
    end
  end

  // new tail position after the operation
  assign tail_idx = IDX_W'(count_d - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      count_out_q <= count_d;
      status_q    <= status_d;
      if (count_d == '0) begin
        largest_q  <= '0;
        smallest_q <= '0;
      end else begin
        largest_q  <= nxt[0];
        smallest_q <= nxt[tail_idx];
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, COUNT_W'(count_out_q), smallest_q, largest_q};
  assign m_axis_tuser_o  = status_q;

  // count never runs past capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("stored count exceeds capacity");

  // a rejected insert reports a full store
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && status_q == ST_FULL) |-> (count_out_q == CNT_W'(CAPACITY)))
    else $error("full status with store not full");

  // a rejected removal reports an empty store with zero values
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && status_q == ST_EMPTY) |->
      (count_out_q == '0 && largest_q == '0 && smallest_q == '0))
    else $error("empty status with store not empty");

  // an accepted insert into a non-full store grows the count by one
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser_i == OP_INSERT && count_q < CNT_W'(CAPACITY)) |=>
      (count_q == $past(count_q) + 1'b1))
    else $error("insert did not grow count");

  // head is never below tail in a reported result
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (largest_q >= smallest_q))
    else $error("largest below smallest");

endmodule
`default_nettype wire

// ===== rtl/core/sdeq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sdeq_cell (
  input  wire                               clk_i,
  input  wire                               en_i,
  input  wire  sdeq_pkg::cmd_t              cmd_i,
  input  wire                               occ_i,
  input  wire                               left_keep_i,
  input  wire  signed [sdeq_pkg::VALUE_W-1:0] left_value_i,
  input  wire  signed [sdeq_pkg::VALUE_W-1:0] right_value_i,
  output logic                              keep_o,
  output logic signed [sdeq_pkg::VALUE_W-1:0] value_o,
  output logic signed [sdeq_pkg::VALUE_W-1:0] next_o
);
  import sdeq_pkg::*;

  logic signed [VALUE_W-1:0] value_q;
  logic signed [VALUE_W-1:0] value_d;

  // occupied entry that stays ahead of the new value
  assign keep_o = occ_i && (value_q >= cmd_i.value);

  always_comb begin
    value_d = value_q;
    if (cmd_i.ins) begin
      if (keep_o) begin
        value_d = value_q;
      end else if (left_keep_i) begin
        value_d = cmd_i.value;
      end else begin
        value_d = left_value_i;
      end
    end else if (cmd_i.rem_head) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;
  assign next_o  = value_d;

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import sdeq_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 750;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    value_t              largest;
    value_t              smallest;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
  } deq_result_t;

  typedef struct {
    logic [OP_W-1:0] op;
    value_t          value;
    bit              typed;
    deq_result_t     result;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic s_valid = 1'b0;
  logic [OP_W-1:0] s_op = '0;
  value_t s_value = '0;
  logic m_ready = 1'b0;
  wire s_ready;
  wire m_valid;
  wire [71:0] m_data;
  wire [1:0] m_status;

  sorted_double_ended_queue_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_value),
    .s_axis_tuser_i  (s_op),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_status)
  );

  always #4 clk = ~clk;

  // predictor state: descending list, head at index 0
  value_t sorted_q[CAPACITY];
  int sorted_len = 0;

  stim_t pending_q[$];
  deq_result_t expected_q[$];
  stim_t dir_rows[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;
  int stall_left = 0;
  int stall_len;
  deq_result_t got;
  deq_result_t want;
  stim_t accepted;

  function automatic deq_result_t apply_op(logic [OP_W-1:0] op, value_t v);
    deq_result_t r;
    int pos;
    r.status = ST_DONE;
    case (op)
      OP_INSERT: begin
        if (sorted_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // equal values keep arrival order
          pos = 0;
          while (pos < sorted_len && sorted_q[pos] >= v) pos++;
          for (int i = sorted_len; i > pos; i--) sorted_q[i] = sorted_q[i-1];
          sorted_q[pos] = v;
          sorted_len++;
        end
      end
      OP_REM_LARGE: begin
        if (sorted_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i + 1 < sorted_len; i++) sorted_q[i] = sorted_q[i+1];
          sorted_len--;
        end
      end
      OP_REM_SMALL: begin
        if (sorted_len == 0) r.status = ST_EMPTY;
        else sorted_len--;
      end
      default: ;
    endcase
    r.count = sorted_len[COUNT_W-1:0];
    r.largest = (sorted_len == 0) ? '0 : sorted_q[0];
    r.smallest = (sorted_len == 0) ? '0 : sorted_q[sorted_len-1];
    return r;
  endfunction

  function automatic stim_t stim(logic [OP_W-1:0] op, value_t v, bit typed = 1'b0,
                                 value_t lg = '0, value_t sm = '0,
                                 int cnt = 0, logic [STATUS_W-1:0] st = ST_DONE);
    stim_t s;
    s.op = op;
    s.value = v;
    s.typed = typed;
    s.result.largest = lg;
    s.result.smallest = sm;
    s.result.count = cnt[COUNT_W-1:0];
    s.result.status = st;
    return s;
  endfunction

  // mostly no gap, often a short one, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 62) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic value_t rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'sh7fffffff;
    if (r == 1) return 32'sh80000000;
    // narrow range gives plenty of equal values
    if (r < 5) return value_t'($signed($urandom_range(0, 8)) - 4);
    return value_t'($urandom);
  endfunction

  task automatic send_item(stim_t s);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pending_q.push_back(s);
    s_valid <= 1'b1;
    s_op <= s.op;
    s_value <= s.value;
    do @(posedge clk); while (!s_ready);
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      stall_len = idle_len();
      if (stall_len > 0) begin
        m_ready <= 1'b0;
        stall_left <= stall_len - 1;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // scoreboard: results are checked before the input of the same edge is predicted
  always @(posedge clk) begin
    if (rst_n) begin
      if (m_valid && m_ready) begin
        got.largest = m_data[31:0];
        got.smallest = m_data[63:32];
        got.count = m_data[68:64];
        got.status = m_status;
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected: largest %0d smallest %0d count %0d status %0d",
                   $time, got.largest, got.smallest, got.count, got.status);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: expected largest %0d smallest %0d count %0d status %0d",
                     $time, want.largest, want.smallest, want.count, want.status);
            $display("%0t:   actual largest %0d smallest %0d count %0d status %0d",
                     $time, got.largest, got.smallest, got.count, got.status);
          end
        end
      end
      if (s_valid && s_ready) begin
        accepted = pending_q.pop_front();
        want = apply_op(accepted.op, accepted.value);
        expected_q.push_back(accepted.typed ? accepted.result : want);
      end
      if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int r;
    bit filling;
    stim_t s;

    // empty store: both removals rejected, unused code is a no-op
    dir_rows.push_back(stim(OP_REM_LARGE, 0, 1, 0, 0, 0, ST_EMPTY));
    dir_rows.push_back(stim(OP_REM_SMALL, 0, 1, 0, 0, 0, ST_EMPTY));
    dir_rows.push_back(stim(OP_UNUSED, 32'sh12345678, 1, 0, 0, 0, ST_DONE));
    // single entry is both head and tail, then the two extremes
    dir_rows.push_back(stim(OP_INSERT, 32'sh7fffffff, 1, 32'sh7fffffff, 32'sh7fffffff, 1));
    dir_rows.push_back(stim(OP_INSERT, 32'sh80000000, 1, 32'sh7fffffff, 32'sh80000000, 2));
    dir_rows.push_back(stim(OP_INSERT, 0));
    dir_rows.push_back(stim(OP_INSERT, -1));
    dir_rows.push_back(stim(OP_INSERT, 0));
    // equal to the current tail
    dir_rows.push_back(stim(OP_INSERT, 32'sh80000000));
    dir_rows.push_back(stim(OP_REM_SMALL, 32'sh7fffffff));
    dir_rows.push_back(stim(OP_REM_LARGE, -1));
    dir_rows.push_back(stim(OP_UNUSED, -1));
    // fill up to capacity
    dir_rows.push_back(stim(OP_INSERT, 32'sh7fffffff));
    dir_rows.push_back(stim(OP_INSERT, 32'sh80000000));
    dir_rows.push_back(stim(OP_INSERT, 1));
    dir_rows.push_back(stim(OP_INSERT, 32'sh55555555));
    dir_rows.push_back(stim(OP_INSERT, 32'shaaaaaaaa));
    dir_rows.push_back(stim(OP_INSERT, -5));
    dir_rows.push_back(stim(OP_INSERT, 32'sh12345678));
    dir_rows.push_back(stim(OP_INSERT, 0));
    dir_rows.push_back(stim(OP_INSERT, 32'sh7fffffff));
    dir_rows.push_back(stim(OP_INSERT, -1));
    dir_rows.push_back(stim(OP_INSERT, 32'sh80000000));
    dir_rows.push_back(stim(OP_INSERT, 32'sh7ffffffe));
    // full store rejects the insert
    dir_rows.push_back(stim(OP_INSERT, 5, 1, 32'sh7fffffff, 32'sh80000000, CAPACITY, ST_FULL));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i]);

    // alternate fill-biased and drain-biased stretches so full and empty recur
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      filling = ((i / 40) % 2) == 0;
      steady = ((i / 60) % 5) == 4;
      r = $urandom_range(0, 99);
      if (r < 3) s = stim(OP_UNUSED, rand_value());
      else if (r < (filling ? 72 : 30)) s = stim(OP_INSERT, rand_value());
      else if ($urandom_range(0, 1) == 0) s = stim(OP_REM_LARGE, rand_value());
      else s = stim(OP_REM_SMALL, rand_value());
      send_item(s);
    end
    steady = 1'b0;
    s_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sdeq_pkg.sv
rtl/core/sdeq_cell.sv
rtl/core/sorted_double_ended_queue_unit.sv
sim/tb.sv
